// File: rtl/core/sha1bs_pkg.sv
`default_nettype none
package sha1bs_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } sha1bs_state_e;

  // working variables a..e
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1bs_wv_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam int unsigned NUM_WORDS = 5;

  function automatic logic [31:0] rotl1(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sha1bs_round.sv
`default_nettype none
// One SHA-1 round: f/K select by round number, five-operand add.
module sha1bs_round (
  input  var sha1bs_pkg::sha1bs_wv_t wv_i,
  input  var logic [6:0]             rnd_i,
  input  var logic [31:0]            w_i,
  output var sha1bs_pkg::sha1bs_wv_t wv_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (wv_i.b & wv_i.c) | (~wv_i.b & wv_i.d);
      k = sha1bs_pkg::K0;
    end else if (rnd_i < 7'd40) begin
      f = wv_i.b ^ wv_i.c ^ wv_i.d;
      k = sha1bs_pkg::K1;
    end else if (rnd_i < 7'd60) begin
      f = (wv_i.b & wv_i.c) | (wv_i.b & wv_i.d) | (wv_i.c & wv_i.d);
      k = sha1bs_pkg::K2;
    end else begin
      f = wv_i.b ^ wv_i.c ^ wv_i.d;
      k = sha1bs_pkg::K3;
    end
  end

  assign t = {wv_i.a[26:0], wv_i.a[31:27]} + f + wv_i.e + k + w_i;

  always_comb begin
    wv_o.a = t;
    wv_o.b = wv_i.a;
    wv_o.c = {wv_i.b[1:0], wv_i.b[31:2]};
    wv_o.d = wv_i.c;
    wv_o.e = wv_i.d;
  end

endmodule
`default_nettype wire

// File: rtl/core/sha1bs_core_top.sv
`default_nettype none
// Digest word select by word index.
module sha1bs_core_top (
  input  var logic [31:0] h0_i,
  input  var logic [31:0] h1_i,
  input  var logic [31:0] h2_i,
  input  var logic [31:0] h3_i,
  input  var logic [31:0] h4_i,
  input  var logic [2:0]  idx_i,
  output var logic [31:0] word_o
);

  always_comb begin
    unique case (idx_i)
      3'd0:    word_o = h0_i;
      3'd1:    word_o = h1_i;
      3'd2:    word_o = h2_i;
      3'd3:    word_o = h3_i;
      default: word_o = h4_i;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/sha1_byte_stream_hasher_core.sv
`default_nettype none
// SHA-1 over a byte stream.
//
//   channel  dir  handshake             payload
//   in       in   in_valid_i/in_stall_o data_byte_i, has_byte_i, end_of_message_i
//   out      out  out_valid_o/out_stall_i digest_word_o, word_index_o, last_word_o
//
// A byte item is taken while idle; the 64th byte of a block adds a compression
// (80 rounds through the single round unit, then the chaining fold).
// An end item pads one byte per cycle (into a second block when the pad
// spills past the first) and compresses each padded block, then
// offers the five digest words, one per cycle while out_stall_i is low.
// Reset loads the initial hash values and clears the byte count; no sweep.
// in_stall_o is high from an accepted block-ending item until its fold is
// done, and from an accepted end item until the last digest word is taken.
module sha1_byte_stream_hasher_core (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output var logic        in_stall_o,
  input  var logic [7:0]  data_byte_i,
  input  var logic        has_byte_i,
  input  var logic        end_of_message_i,
  output var logic        out_valid_o,
  input  var logic        out_stall_i,
  output var logic [31:0] digest_word_o,
  output var logic [2:0]  word_index_o,
  output var logic        last_word_o
);

  sha1bs_pkg::sha1bs_state_e state_q, state_d;

  logic [31:0] blk_q [16];       // message schedule / byte gather line
  sha1bs_pkg::sha1bs_wv_t wv_q, wv_rnd;
  logic [31:0] h_q [5];
  logic [60:0] cnt_q;
  logic [5:0]  pos_q;
  logic [6:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        end_pend_q;       // message end waiting behind a compression
  logic        pad_first_q;      // next pad byte is the 0x80 marker
  logic        pad_wrap_q;       // marker landed in 56..62: zero-fill to a fresh block
  logic        final_q;          // compression in flight is the last one

  logic        in_acc;
  logic        out_acc;
  logic        shift_byte;
  logic [7:0]  byte_in;
  logic        len_phase;
  logic [63:0] bits;
  logic [7:0]  len_byte;
  logic [31:0] w_cur;
  logic        pos_last;

  assign in_acc   = in_valid_i && (state_q == sha1bs_pkg::S_IDLE);
  assign out_acc  = out_valid_o && !out_stall_i;
  assign pos_last = (pos_q == 6'd63);

  assign bits      = {cnt_q, 3'b000};
  assign len_byte  = 8'(bits >> {3'd7 - pos_q[2:0], 3'b000});
  assign len_phase = !pad_first_q && !pad_wrap_q && (pos_q[5:3] == 3'd7);

  // round word: rotate the first 16, expand afterwards
  assign w_cur = (rnd_q < 7'd16) ? blk_q[0]
               : sha1bs_pkg::rotl1(blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0]);

  sha1bs_round u_round (
    .wv_i  (wv_q),
    .rnd_i (rnd_q),
    .w_i   (w_cur),
    .wv_o  (wv_rnd)
  );

  sha1bs_core_top u_sel (
    .h0_i   (h_q[0]),
    .h1_i   (h_q[1]),
    .h2_i   (h_q[2]),
    .h3_i   (h_q[3]),
    .h4_i   (h_q[4]),
    .idx_i  (idx_q),
    .word_o (digest_word_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha1bs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (has_byte_i && pos_last) state_d = sha1bs_pkg::S_ROUND;
          else if (end_of_message_i)  state_d = sha1bs_pkg::S_PAD;
        end
      end
      sha1bs_pkg::S_ROUND: begin
        if (rnd_q == sha1bs_pkg::LAST_ROUND) state_d = sha1bs_pkg::S_FOLD;
      end
      sha1bs_pkg::S_FOLD: begin
        if (final_q)         state_d = sha1bs_pkg::S_OUT;
        else if (end_pend_q) state_d = sha1bs_pkg::S_PAD;
        else                 state_d = sha1bs_pkg::S_IDLE;
      end
      sha1bs_pkg::S_PAD: begin
        if (pos_last) state_d = sha1bs_pkg::S_ROUND;
      end
      sha1bs_pkg::S_OUT: begin
        if (out_acc && last_word_o) state_d = sha1bs_pkg::S_IDLE;
      end
      default: state_d = sha1bs_pkg::S_IDLE;
    endcase
  end

  // outputs and byte path control
  always_comb begin
    in_stall_o  = (state_q != sha1bs_pkg::S_IDLE);
    out_valid_o = (state_q == sha1bs_pkg::S_OUT);
    shift_byte  = 1'b0;
    byte_in     = data_byte_i;
    unique case (state_q)
      sha1bs_pkg::S_IDLE: shift_byte = in_acc && has_byte_i;
      sha1bs_pkg::S_PAD: begin
        shift_byte = 1'b1;
        if (pad_first_q)    byte_in = sha1bs_pkg::PAD_BYTE;
        else if (len_phase) byte_in = len_byte;
        else                byte_in = 8'h00;
      end
      default: ;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'(sha1bs_pkg::NUM_WORDS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1bs_pkg::S_IDLE;
      h_q[0]      <= sha1bs_pkg::H0;
      h_q[1]      <= sha1bs_pkg::H1;
      h_q[2]      <= sha1bs_pkg::H2;
      h_q[3]      <= sha1bs_pkg::H3;
      h_q[4]      <= sha1bs_pkg::H4;
      cnt_q       <= '0;
      pos_q       <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      end_pend_q  <= 1'b0;
      pad_first_q <= 1'b1;
      pad_wrap_q  <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift_byte) pos_q <= pos_q + 6'd1;
      if (state_q == sha1bs_pkg::S_IDLE && in_acc) begin
        if (has_byte_i) cnt_q <= cnt_q + 61'd1;
        end_pend_q <= end_of_message_i;
      end
      if (state_q == sha1bs_pkg::S_PAD) begin
        pad_first_q <= 1'b0;
        if (pad_first_q) pad_wrap_q <= (pos_q[5:3] == 3'd7) && !pos_last;
        else if (pos_last) pad_wrap_q <= 1'b0;
        if (pos_last && len_phase) final_q <= 1'b1;
      end
      if (state_q == sha1bs_pkg::S_ROUND) rnd_q <= rnd_q + 7'd1;
      if (state_q == sha1bs_pkg::S_FOLD) begin
        rnd_q  <= '0;
        h_q[0] <= h_q[0] + wv_q.a;
        h_q[1] <= h_q[1] + wv_q.b;
        h_q[2] <= h_q[2] + wv_q.c;
        h_q[3] <= h_q[3] + wv_q.d;
        h_q[4] <= h_q[4] + wv_q.e;
      end
      if (out_acc) begin
        if (last_word_o) begin
          // ready for the next message
          idx_q       <= '0;
          h_q[0]      <= sha1bs_pkg::H0;
          h_q[1]      <= sha1bs_pkg::H1;
          h_q[2]      <= sha1bs_pkg::H2;
          h_q[3]      <= sha1bs_pkg::H3;
          h_q[4]      <= sha1bs_pkg::H4;
          cnt_q       <= '0;
          pos_q       <= '0;
          end_pend_q  <= 1'b0;
          pad_first_q <= 1'b1;
          pad_wrap_q  <= 1'b0;
          final_q     <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  // block line and working variables
  always_ff @(posedge clk_i) begin
    if (shift_byte) begin
      for (int k = 0; k < 15; k++) blk_q[k] <= {blk_q[k][23:0], blk_q[k+1][31:24]};
      blk_q[15] <= {blk_q[15][23:0], byte_in};
    end else if (state_q == sha1bs_pkg::S_ROUND) begin
      for (int k = 0; k < 15; k++) blk_q[k] <= blk_q[k+1];
      blk_q[15] <= w_cur;
    end
    if (state_q == sha1bs_pkg::S_ROUND) begin
      wv_q <= wv_rnd;
    end else if (state_d == sha1bs_pkg::S_ROUND) begin
      // entering a compression: the block's last byte lands this same edge
      wv_q.a <= h_q[0];
      wv_q.b <= h_q[1];
      wv_q.c <= h_q[2];
      wv_q.d <= h_q[3];
      wv_q.e <= h_q[4];
    end
  end

endmodule
`default_nettype wire
